// File: rtl/core/stlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential turn lamp controller package
// Shared widths, codes, lamp groups and the result record.
// ----------------------------------------------------------------------------
package stlc_pkg;

  // Widths of the configuration registers, the default step timer and the pin, lamp, duty and step fields.
  localparam int unsigned DELAY_W        = 16;
  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned PINS_W         = 5;
  localparam int unsigned LAMPS_W        = 10;
  localparam int unsigned DUTY_W         = 2;
  localparam int unsigned STEP_W         = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_DELAY   = 1'd1;

  // Reset values of the delay registers.
  localparam logic [DELAY_W-1:0] NORMAL_DELAY_RST = 16'd100;
  localparam logic [DELAY_W-1:0] TEST_DELAY_RST   = 16'd10;

  // Bit positions of the pins in a sample.
  localparam int unsigned PIN_TURN  = 0;
  localparam int unsigned PIN_DRL   = 1;
  localparam int unsigned PIN_POS   = 2;
  localparam int unsigned PIN_WHITE = 3;
  localparam int unsigned PIN_TEST  = 4;

  // Lamp groups of the turn sequence.
  localparam logic [LAMPS_W-1:0] YELLOW_ALL = 10'h3FF;
  localparam logic [LAMPS_W-1:0] GROUP_A    = 10'h023;
  localparam logic [LAMPS_W-1:0] GROUP_B    = 10'h04C;
  localparam logic [LAMPS_W-1:0] GROUP_C    = 10'h190;
  localparam logic [LAMPS_W-1:0] GROUP_D    = 10'h200;

  // Duty codes.
  localparam logic [DUTY_W-1:0] DUTY_POS  = 2'd0;
  localparam logic [DUTY_W-1:0] DUTY_DRL  = 2'd1;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 2'd2;

  // Sequence step codes.
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_A    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_B    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_C    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_D    = 3'd4;

  // One result beat.
  typedef struct packed {
    logic               side_light;
    logic [DUTY_W-1:0]  duty_code;
    logic               white_lamp;
    logic [LAMPS_W-1:0] yellow_lamps;
  } result_t;

endpackage

// File: rtl/core/stlc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn lamp core
// Debounce, timed turn sequence and steady-light decision for one tick beat.
// ----------------------------------------------------------------------------
module stlc_core
  import stlc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [PINS_W-1:0]  sample_i,
  input  logic [DELAY_W-1:0] normal_delay_i,
  input  logic [DELAY_W-1:0] test_delay_i,
  output result_t            result_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [PINS_W-1:0]     prev_q, prev_d;
  logic [PINS_W-1:0]     stable_q, stable_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [LAMPS_W-1:0]    yellow_q, yellow_d;
  logic                  white_q, white_d;
  logic [DUTY_W-1:0]     duty_q, duty_d;
  logic [DELAY_W-1:0]    delay;
  logic                  timer_done;

  // Debounce: a repeated sample becomes the stable pin set.
  always_comb begin
    prev_d   = prev_q;
    stable_d = stable_q;
    if (sample_i != prev_q) begin
      prev_d = sample_i;
    end else begin
      stable_d = sample_i;
    end
  end

  // Step delay selection and the compare against the incremented timer.
  always_comb begin
    logic [TIMER_BITS-1:0] timer_inc;
    timer_inc  = (timer_q != TIMER_MAX) ? timer_q + 1'b1 : timer_q;
    delay      = stable_d[PIN_TEST] ? test_delay_i : normal_delay_i;
    timer_done = CMP_W'(timer_inc) >= CMP_W'(delay);
    timer_d    = timer_inc;
    step_d     = step_q;
    yellow_d   = yellow_q;
    white_d    = white_q;
    duty_d     = duty_q;

    // Turn sequence.
    if (!stable_d[PIN_TURN]) begin
      step_d = STEP_IDLE;
    end else begin
      unique case (step_q)
        STEP_IDLE: begin
          yellow_d = GROUP_A;
          white_d  = 1'b0;
          duty_d   = DUTY_FULL;
          step_d   = STEP_A;
          timer_d  = '0;
        end
        STEP_A, STEP_B, STEP_C: begin
          if (timer_done) begin
            step_d  = step_q + 1'b1;
            timer_d = '0;
            case (step_q)
              STEP_A:  yellow_d = yellow_q | GROUP_B;
              STEP_B:  yellow_d = yellow_q | GROUP_C;
              default: yellow_d = yellow_q | GROUP_D;
            endcase
          end
        end
        STEP_D: begin
        end
        default: begin
          step_d  = STEP_IDLE;
          timer_d = '0;
        end
      endcase
    end

    // Steady lights while turn is off.
    if (!stable_d[PIN_TURN]) begin
      if (stable_d[PIN_DRL] || stable_d[PIN_POS]) begin
        white_d  = stable_d[PIN_WHITE];
        yellow_d = stable_d[PIN_WHITE] ? '0 : YELLOW_ALL;
        duty_d   = stable_d[PIN_DRL] ? DUTY_DRL : DUTY_POS;
      end else begin
        yellow_d = '0;
        white_d  = 1'b0;
        duty_d   = DUTY_FULL;
      end
    end
  end

  // State update on every accepted tick beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      step_q   <= STEP_IDLE;
      timer_q  <= '0;
      yellow_q <= '0;
      white_q  <= 1'b0;
      duty_q   <= DUTY_POS;
    end else if (accept_i) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      step_q   <= step_d;
      timer_q  <= timer_d;
      yellow_q <= yellow_d;
      white_q  <= white_d;
      duty_q   <= duty_d;
    end
  end

  // The result reflects the state after this tick.
  assign result_o.yellow_lamps = yellow_d;
  assign result_o.white_lamp   = white_d;
  assign result_o.duty_code    = duty_d;
  assign result_o.side_light   = stable_d[PIN_POS];

  // White and yellow lamps are never lit together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    white_q |-> (yellow_q == '0))
    else $error("white and yellow lamps lit together");

  // A tick with stable turn low leaves the sequence idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !stable_d[PIN_TURN]) |=> (step_q == STEP_IDLE))
    else $error("sequence not idle after turn dropped");

  // While the sequence runs, the first lamp group stays lit at full duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != STEP_IDLE) |-> ((yellow_q & GROUP_A) == GROUP_A && duty_q == DUTY_FULL))
    else $error("turn sequence lost its first group");

endmodule

// File: rtl/core/stlc_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output buffer
// Two-entry output register with a skid stage, so a new beat is taken while
// one finished result still waits downstream.
// ----------------------------------------------------------------------------
module stlc_skid
  import stlc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    main_valid_q;
  logic    skid_valid_q;
  result_t main_q;
  result_t skid_q;
  logic    push;
  logic    pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign pop         = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end else if (push && (pop || !main_valid_q)) begin
      main_q <= in_data_i;
    end else if (push) begin
      skid_q <= in_data_i;
    end
  end

  // The skid stage only fills behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry without main entry");

  // A full buffer that is not drained takes no beat and stays full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("skid entry lost");

  // A waiting skid entry moves forward when the main entry drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_valid_q && main_q == $past(skid_q)))
    else $error("skid entry not forwarded");

endmodule

// File: rtl/core/sequential_turn_lamp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential turn lamp controller
// Debounces the lamp request pins and drives the ten-lamp sequential turn
// pattern or the steady DRL and position lights, one result per tick beat.
// ----------------------------------------------------------------------------
// Each tick beat is handled by combinational core logic between the state
// registers and the output buffer, so a beat is accepted every cycle while
// s_axis_tready is high, and its result is registered there. The two-entry
// buffer keeps s_axis_tready high while one result waits; tready falls only
// when two results are held. The user must write the step delays through the
// configuration port only while no beat is in flight; nothing enforces it.
module sequential_turn_lamp_controller
  import stlc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Tick beat: turn_raw, drl_raw, pos_raw, white_raw, test_raw, zero pad.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result beat: yellow_lamps, white_lamp, duty_code, side_light, zero pad.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DELAY_W-1:0]     cfg_data_i
);

  logic [DELAY_W-1:0] normal_delay_q;
  logic [DELAY_W-1:0] test_delay_q;
  logic               accept;
  result_t            core_result;
  result_t            out_result;

  // Delay registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_delay_q <= NORMAL_DELAY_RST;
      test_delay_q   <= TEST_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORMAL_DELAY: normal_delay_q <= cfg_data_i;
        CFG_TEST_DELAY:   test_delay_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  stlc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .sample_i      (s_axis_tdata[PINS_W-1:0]),
    .normal_delay_i(normal_delay_q),
    .test_delay_i  (test_delay_q),
    .result_o      (core_result)
  );

  stlc_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (core_result),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_result)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_axis_tdata = {
    {(OUT_TDATA_W - LAMPS_W - DUTY_W - 2){1'b0}},
    out_result.side_light,
    out_result.duty_code,
    out_result.white_lamp,
    out_result.yellow_lamps
  };

endmodule
